### hdl/lnr_pkg.sv
`default_nettype none
package lnr_pkg;

	// Fixed field widths.
	localparam int SAMPLE_W    = 16;
	localparam int LEN_W       = 7;
	localparam int MAX_ROW_DEF = 64;

	// Internal arithmetic widths, sized for rows of up to 64 samples.
	localparam int SUM_W   = 22;
	localparam int MEAN_W  = 24;
	localparam int ABS_W   = 25;
	localparam int NUM_W   = 56;
	localparam int DEN_W   = 32;
	localparam int ROOT_W  = 28;

	// Divider request and response.
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             busy;
		logic [NUM_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_V_RD,
		ST_V_ABS,
		ST_V_MUL,
		ST_V_ACC,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_SQRT,
		ST_O_RD,
		ST_O_ABS,
		ST_O_GO,
		ST_O_WAIT,
		ST_O_PUT
	} lnr_state_t;

endpackage
`default_nettype wire

### hdl/lnr_if.sv
`default_nettype none
// Input channel: one Q8.8 sample per item.
interface lnr_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// Output channel: one Q4.12 normalized value per item.
interface lnr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] normalized;
	logic        last_of_row;
	modport source (output valid, output normalized, output last_of_row, input ready);
	modport sink (input valid, input normalized, input last_of_row, output ready);
endinterface
`default_nettype wire

### hdl/lnr_div.sv
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module lnr_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lnr_pkg::div_req_t req,
	output lnr_pkg::div_rsp_t      rsp
);
	import lnr_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// Shift in the next numerator bit and try a subtraction.
	always_comb begin
		trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q[DEN_W-1:0];

endmodule
`default_nettype wire

### hdl/layer_norm_row_unit.sv
`default_nettype none
// Layer normalization of one row of signed Q8.8 samples, no gain or bias. Samples are
// taken one per cycle, while the unit is loading, into a row memory and a running
// sum is kept; the sample that completes the row (row_length of them, 0 counting as
// 1 and values above MAX_ROW as MAX_ROW) starts the computation, and input stalls
// until the last result of the row has been loaded into the output register. All
// divisions go through one shared bit-serial divider. The mean takes one division;
// the variance pass reads each sample, takes its absolute deviation from the mean,
// squares it and accumulates it, then issues another division; the square root is
// found bit by bit; and each output reads its sample, forms the deviation, issues
// the division, waits on the divider and loads the output register once the
// receiver has taken any previous result. Outputs are Q4.12, saturated, with
// last_of_row on the final one. Writing row_length drops any partial row.
module layer_norm_row_unit #(
	parameter int MAX_ROW = lnr_pkg::MAX_ROW_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [lnr_pkg::LEN_W-1:0] cfg_wdata,
	lnr_in_if.sink                        in_ch,
	lnr_out_if.source                     out_ch
);
	import lnr_pkg::*;

	localparam int AW    = $clog2(MAX_ROW);
	localparam int CNT_W = $clog2(MAX_ROW + 1);

	lnr_state_t state_q, state_d;

	logic [SAMPLE_W-1:0] row_mem [MAX_ROW];
	logic [SAMPLE_W-1:0] mem_q;

	logic [LEN_W-1:0]       len_q;
	logic [CNT_W-1:0]       len_eff;
	logic [CNT_W-1:0]       fill_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       j_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic                   mneg_q;
	logic [ABS_W-1:0]       a_q;
	logic                   dneg_q;
	logic [2*ABS_W-1:0]     prod_q;
	logic [NUM_W-1:0]       sq_q;
	logic [NUM_W-1:0]       rad_q;
	logic [NUM_W-1:0]       res_q;
	logic [NUM_W-1:0]       bit_q;
	logic [ROOT_W-1:0]      root_q;
	logic                   ov_q;
	logic [15:0]            onorm_q;
	logic                   olast_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                 in_acc;
	logic                 out_load;
	logic                 last_j;
	logic signed [31:0]   mnum;
	logic [31:0]          mabs;
	logic signed [25:0]   dev;
	logic [ABS_W-1:0]     dabs;
	logic [NUM_W-1:0]     sq_try;
	logic                 sq_fit;
	logic [15:0]          oval;
	logic [NUM_W-1:0]     mean_mag;

	lnr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Effective row length.
	always_comb begin
		if (len_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (len_q > LEN_W'(MAX_ROW)) begin
			len_eff = CNT_W'(MAX_ROW);
		end else begin
			len_eff = CNT_W'(len_q);
		end
	end

	// Datapath arithmetic shared by the passes.
	always_comb begin
		mnum     = (32'(sum_q) <<< 9) + 32'(cnt_q);
		mabs     = mnum[31] ? 32'(-mnum) : 32'(mnum);
		dev      = {{2{mem_q[15]}}, mem_q, 8'b0} - {{2{mean_q[MEAN_W-1]}}, mean_q};
		dabs     = dev[25] ? ABS_W'(-dev) : ABS_W'(dev);
		sq_try   = res_q + bit_q;
		sq_fit   = rad_q >= sq_try;
		last_j   = (j_q == cnt_q - 1'b1);
		mean_mag = div_rsp.quo + NUM_W'(div_rsp.rem != '0);
		if (dneg_q) begin
			oval = (div_rsp.quo >= NUM_W'(32768)) ? 16'h8000 : 16'(-div_rsp.quo[15:0]);
		end else begin
			oval = (div_rsp.quo >= NUM_W'(32767)) ? 16'h7fff : div_rsp.quo[15:0];
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, handshakes and divider requests.
	always_comb begin
		state_d      = state_q;
		in_ch.ready  = 1'b0;
		out_load     = 1'b0;
		div_req      = '0;
		case (state_q)
			ST_LOAD: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid && (fill_q + 1'b1 == len_eff)) begin
					state_d = ST_MEAN_GO;
				end
			end
			ST_MEAN_GO: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'(mabs);
				div_req.den   = DEN_W'({cnt_q, 1'b0});
				state_d       = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_V_RD;
				end
			end
			ST_V_RD:  state_d = ST_V_ABS;
			ST_V_ABS: state_d = ST_V_MUL;
			ST_V_MUL: state_d = ST_V_ACC;
			ST_V_ACC: begin
				state_d = last_j ? ST_VAR_GO : ST_V_RD;
			end
			ST_VAR_GO: begin
				div_req.start = 1'b1;
				div_req.num   = sq_q;
				div_req.den   = DEN_W'(cnt_q);
				state_d       = ST_VAR_WAIT;
			end
			ST_VAR_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (bit_q[0]) begin
					state_d = ST_O_RD;
				end
			end
			ST_O_RD:  state_d = ST_O_ABS;
			ST_O_ABS: state_d = ST_O_GO;
			ST_O_GO: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'({a_q, 13'b0}) + NUM_W'(root_q);
				div_req.den   = DEN_W'({root_q, 1'b0});
				state_d       = ST_O_WAIT;
			end
			ST_O_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_O_PUT;
				end
			end
			ST_O_PUT: begin
				if (!ov_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = last_j ? ST_LOAD : ST_O_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	assign in_acc = in_ch.valid && in_ch.ready;

	// Row memory: one write port for loading, one registered read port.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_mem[fill_q[AW-1:0]] <= in_ch.sample;
		end
		mem_q <= row_mem[j_q[AW-1:0]];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_W'(64);
			fill_q <= '0;
			sum_q  <= '0;
			ov_q   <= 1'b0;
			j_q    <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				len_q  <= cfg_wdata;
				fill_q <= '0;
				sum_q  <= '0;
			end else if (in_acc) begin
				fill_q <= fill_q + 1'b1;
				sum_q  <= sum_q + SUM_W'(signed'(in_ch.sample));
				cnt_q  <= fill_q + 1'b1;
			end else if (out_load && last_j) begin
				fill_q <= '0;
				sum_q  <= '0;
			end
			if (state_q == ST_MEAN_WAIT || state_q == ST_SQRT) begin
				j_q <= '0;
			end else if (state_q == ST_V_ACC || out_load) begin
				j_q <= j_q + 1'b1;
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Mean, variance, root and output payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_MEAN_GO) begin
			mneg_q <= mnum[31];
		end
		if (state_q == ST_MEAN_WAIT && div_rsp.done) begin
			mean_q <= mneg_q ? MEAN_W'(-mean_mag) : MEAN_W'(div_rsp.quo);
			sq_q   <= '0;
		end
		if (state_q == ST_V_ABS || state_q == ST_O_ABS) begin
			a_q    <= dabs;
			dneg_q <= dev[25];
		end
		if (state_q == ST_V_MUL) begin
			prod_q <= a_q * a_q;
		end
		if (state_q == ST_V_ACC) begin
			sq_q <= sq_q + NUM_W'(prod_q);
		end
		if (state_q == ST_VAR_WAIT && div_rsp.done) begin
			rad_q <= ((div_rsp.quo >> 16) + NUM_W'(1)) << 16;
			res_q <= '0;
			bit_q <= NUM_W'(1) << (NUM_W - 2);
		end
		// One bit of the integer square root per cycle.
		if (state_q == ST_SQRT) begin
			if (sq_fit) begin
				rad_q <= rad_q - sq_try;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (state_q == ST_O_RD) begin
			root_q <= res_q[ROOT_W-1:0];
		end
		if (out_load) begin
			onorm_q <= oval;
			olast_q <= last_j;
		end
	end

	assign out_ch.valid       = ov_q;
	assign out_ch.normalized  = onorm_q;
	assign out_ch.last_of_row = olast_q;

	// Input is only taken while no row computation is in flight.
	a_in_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !div_rsp.busy)
		else $error("input accepted while divider busy");

	// The fill count never reaches the effective length while loading.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (fill_q < len_eff))
		else $error("fill count out of range");

	// The epsilon keeps the root at least 1/256 (256 in Q12.16).
	a_root_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_O_ABS) |-> (root_q >= ROOT_W'(256)))
		else $error("root below epsilon floor");

	// A result is loaded only once the divider has finished.
	a_put_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !div_rsp.busy)
		else $error("result loaded while divider busy");

endmodule
`default_nettype wire
